@@ rtl/core/length_prefixed_frame_decoder_core_macros.svh @@
// Assertion macros used by the checker file of the frame decoder.
// No dependencies; include by bare file name.
`ifndef LENGTH_PREFIXED_FRAME_DECODER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LPFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is low.
`define LPFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

@@ rtl/core/lpfd_pkg.sv @@
// Types, codes and constants of the length-prefixed frame decoder.
// No dependencies; used by every module of the block by scoped name.
`default_nettype none

package lpfd_pkg;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd16777216;
    localparam logic [7:0]  FLAG_MASK_RESET   = 8'hFF;

    // Header byte positions (16-byte header).
    localparam logic [3:0] HDR_LEN_FIRST  = 4'd0;
    localparam logic [3:0] HDR_LEN_LAST   = 4'd3;
    localparam logic [3:0] HDR_CHANNEL    = 4'd4;
    localparam logic [3:0] HDR_FLAGS      = 4'd5;
    localparam logic [3:0] HDR_RSVD_FIRST = 4'd6;
    localparam logic [3:0] HDR_RSVD_LAST  = 4'd7;
    localparam logic [3:0] HDR_LAST       = 4'd15;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_FAILED  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_LENGTH   = 2'd1,
        ERR_FLAGS    = 2'd2,
        ERR_RESERVED = 2'd3
    } err_t;

    typedef enum logic {
        CMD_DATA    = 1'b0,
        CMD_RESTART = 1'b1
    } cmd_t;

    typedef enum logic {
        CFG_MAX_PAYLOAD = 1'b0,
        CFG_FLAG_MASK   = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] max_payload_bytes;
        logic [7:0]  known_flag_mask;
    } cfg_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] data_byte;
        logic       chunk_end;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  channel;
        logic [7:0]  frame_flags;
        logic [63:0] timestamp;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
        err_t        error_code;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/lpfd_in_stage.sv @@
// Input register of the frame decoder: holds one accepted stream transfer.
// Depends on lpfd_pkg.
`default_nettype none

module lpfd_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lpfd_pkg::in_item_t s_item,
    input  wire logic              advance,
    output logic                   item_valid,
    output lpfd_pkg::in_item_t     item
);

    logic               valid_reg;
    logic               valid_next;
    lpfd_pkg::in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload: load on every accepted transfer.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

@@ rtl/core/lpfd_parser.sv @@
// Header parser and payload pass-through: frame state and per-byte logic.
// Depends on lpfd_pkg.
`default_nettype none

module lpfd_parser (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire lpfd_pkg::in_item_t item,
    input  wire lpfd_pkg::cfg_t     cfg,
    output logic                    res_valid,
    output lpfd_pkg::result_t       result
);

    lpfd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       count_reg, count_next;
    logic [31:0]      length_reg, length_next;
    logic [7:0]       channel_reg, channel_next;
    logic [7:0]       flags_reg, flags_next;
    logic             rsvd_reg, rsvd_next;
    logic [63:0]      time_reg, time_next;
    logic [31:0]      left_reg, left_next;
    lpfd_pkg::err_t   fail_reg, fail_next;

    logic             restart;
    logic             hdr_done;
    logic [31:0]      left_dec;
    logic [63:0]      time_shifted;
    lpfd_pkg::err_t   check_code;

    assign restart      = (item.command == lpfd_pkg::CMD_RESTART);
    assign hdr_done     = (count_reg == lpfd_pkg::HDR_LAST);
    assign left_dec     = left_reg - 32'd1;
    assign time_shifted = {time_reg[55:0], item.data_byte};

    // Header checks in priority order; valid once the whole header is in.
    always_comb begin
        if (length_reg > cfg.max_payload_bytes) begin
            check_code = lpfd_pkg::ERR_LENGTH;
        end else if ((flags_reg & ~cfg.known_flag_mask) != 8'd0) begin
            check_code = lpfd_pkg::ERR_FLAGS;
        end else if (rsvd_reg) begin
            check_code = lpfd_pkg::ERR_RESERVED;
        end else begin
            check_code = lpfd_pkg::ERR_NONE;
        end
    end

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (restart) begin
            phase_next = lpfd_pkg::PH_HEADER;
        end else begin
            unique case (phase_reg)
                lpfd_pkg::PH_FAILED: begin
                    phase_next = lpfd_pkg::PH_FAILED;
                end
                lpfd_pkg::PH_PAYLOAD: begin
                    if (left_dec == 32'd0) begin
                        phase_next = lpfd_pkg::PH_HEADER;
                    end
                end
                default: begin
                    if (hdr_done) begin
                        if (check_code != lpfd_pkg::ERR_NONE) begin
                            phase_next = lpfd_pkg::PH_FAILED;
                        end else if (length_reg == 32'd0) begin
                            phase_next = lpfd_pkg::PH_HEADER;
                        end else begin
                            phase_next = lpfd_pkg::PH_PAYLOAD;
                        end
                    end else begin
                        phase_next = lpfd_pkg::PH_HEADER;
                    end
                end
            endcase
        end
    end

    // Datapath and result.
    always_comb begin
        count_next   = count_reg;
        length_next  = length_reg;
        channel_next = channel_reg;
        flags_next   = flags_reg;
        rsvd_next    = rsvd_reg;
        time_next    = time_reg;
        left_next    = left_reg;
        fail_next    = fail_reg;
        res_valid    = 1'b0;
        result       = '0;

        if (restart) begin
            count_next   = '0;
            length_next  = '0;
            channel_next = '0;
            flags_next   = '0;
            rsvd_next    = 1'b0;
            time_next    = '0;
            left_next    = '0;
            fail_next    = lpfd_pkg::ERR_NONE;
        end else begin
            unique case (phase_reg)
                lpfd_pkg::PH_FAILED: begin
                    res_valid         = item.chunk_end;
                    result.kind       = lpfd_pkg::KIND_ERROR;
                    result.error_code = fail_reg;
                end
                lpfd_pkg::PH_PAYLOAD: begin
                    left_next             = left_dec;
                    res_valid             = 1'b1;
                    result.kind           = lpfd_pkg::KIND_PAYLOAD;
                    result.channel        = channel_reg;
                    result.frame_flags    = flags_reg;
                    result.timestamp      = time_reg;
                    result.payload_length = length_reg;
                    result.payload_byte   = item.data_byte;
                    result.last           = (left_dec == 32'd0);
                end
                default: begin
                    if (count_reg == lpfd_pkg::HDR_LEN_FIRST) begin
                        rsvd_next = 1'b0;
                    end
                    case (count_reg) inside
                        [lpfd_pkg::HDR_LEN_FIRST:lpfd_pkg::HDR_LEN_LAST]: begin
                            length_next = {length_reg[23:0], item.data_byte};
                        end
                        lpfd_pkg::HDR_CHANNEL: begin
                            channel_next = item.data_byte;
                        end
                        lpfd_pkg::HDR_FLAGS: begin
                            flags_next = item.data_byte;
                        end
                        [lpfd_pkg::HDR_RSVD_FIRST:lpfd_pkg::HDR_RSVD_LAST]: begin
                            rsvd_next = rsvd_reg | (item.data_byte != 8'd0);
                        end
                        default: begin
                            time_next = time_shifted;
                        end
                    endcase

                    count_next = count_reg + 4'd1;
                    if (hdr_done) begin
                        fail_next = check_code;
                        if (check_code != lpfd_pkg::ERR_NONE) begin
                            res_valid         = item.chunk_end;
                            result.kind       = lpfd_pkg::KIND_ERROR;
                            result.error_code = check_code;
                        end else begin
                            left_next             = length_reg;
                            res_valid             = 1'b1;
                            result.kind           = lpfd_pkg::KIND_HEADER;
                            result.channel        = channel_reg;
                            result.frame_flags    = flags_reg;
                            result.timestamp      = time_shifted;
                            result.payload_length = length_reg;
                            result.last           = (length_reg == 32'd0);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= lpfd_pkg::PH_HEADER;
            count_reg   <= '0;
            length_reg  <= '0;
            channel_reg <= '0;
            flags_reg   <= '0;
            rsvd_reg    <= 1'b0;
            time_reg    <= '0;
            left_reg    <= '0;
            fail_reg    <= lpfd_pkg::ERR_NONE;
        end else if (advance) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            channel_reg <= channel_next;
            flags_reg   <= flags_next;
            rsvd_reg    <= rsvd_next;
            time_reg    <= time_next;
            left_reg    <= left_next;
            fail_reg    <= fail_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lpfd_out_stage.sv @@
// Result register of the frame decoder: holds one result until taken.
// Depends on lpfd_pkg.
`default_nettype none

module lpfd_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire lpfd_pkg::result_t result,
    output logic                   slot_free,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lpfd_pkg::result_t      m_result
);

    logic              valid_reg;
    logic              valid_next;
    lpfd_pkg::result_t result_reg;

    assign slot_free  = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

@@ rtl/core/length_prefixed_frame_decoder_core.sv @@
// Length-prefixed frame decoder, top level: config registers and stage wiring.
// Depends on lpfd_pkg, lpfd_in_stage, lpfd_parser and lpfd_out_stage.
//
// The block takes one stream byte per transfer and parses 16-byte headers
// (big-endian 32-bit length, channel, flags, two reserved bytes, big-endian
// 64-bit timestamp). After the last header byte it checks, in this order, the
// length against max_payload_bytes, the flags against known_flag_mask, and that
// the reserved bytes are zero. A good header gives a header record (kind 0),
// then each payload byte comes out as kind 1 with last set on the final one;
// an empty frame sets last on its header record. A failed check is sticky: an
// error report (kind 2) comes out for each later byte marked chunk_end, and on
// the failing header byte itself if it is marked so, until a restart command
// (s_command = 1) clears all frame state. Configuration registers survive a
// restart. Throughput is one byte per clock while the result register is free or
// being taken: each byte is held in the input register, makes one pass through
// the parser, and its result is held in the result register that drives
// m_valid. s_ready stays high unless both registers are full and m_ready is
// low. Write configuration only while idle; cfg_ready is always high.
`default_nettype none

module length_prefixed_frame_decoder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_chunk_end,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_channel,
    output logic [7:0]       m_frame_flags,
    output logic [63:0]      m_timestamp,
    output logic [31:0]      m_payload_length,
    output logic [7:0]       m_payload_byte,
    output logic             m_last,
    output logic [1:0]       m_error_code
);

    lpfd_pkg::cfg_t     cfg_reg;
    lpfd_pkg::cfg_t     cfg_next;
    lpfd_pkg::in_item_t s_item;
    lpfd_pkg::in_item_t item;
    lpfd_pkg::result_t  result;
    lpfd_pkg::result_t  m_result;
    logic               item_valid;
    logic               res_valid;
    logic               slot_free;
    logic               advance;

    // Configuration: always ready, decode the register index.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (lpfd_pkg::cfg_idx_t'(cfg_index))
                lpfd_pkg::CFG_MAX_PAYLOAD: cfg_next.max_payload_bytes = cfg_data;
                lpfd_pkg::CFG_FLAG_MASK:   cfg_next.known_flag_mask   = cfg_data[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_payload_bytes <= lpfd_pkg::MAX_PAYLOAD_RESET;
            cfg_reg.known_flag_mask   <= lpfd_pkg::FLAG_MASK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Pack the input transfer.
    assign s_item.command   = lpfd_pkg::cmd_t'(s_command);
    assign s_item.data_byte = s_data_byte;
    assign s_item.chunk_end = s_chunk_end;

    // Advance the held byte whenever the result slot can take what it makes;
    // bytes that make no result still wait for that, which keeps order simple.
    assign advance = item_valid && slot_free;

    lpfd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lpfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .result    (result)
    );

    lpfd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && res_valid),
        .result    (result),
        .slot_free (slot_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    // Unpack the result transfer.
    assign m_kind           = m_result.kind;
    assign m_channel        = m_result.channel;
    assign m_frame_flags    = m_result.frame_flags;
    assign m_timestamp      = m_result.timestamp;
    assign m_payload_length = m_result.payload_length;
    assign m_payload_byte   = m_result.payload_byte;
    assign m_last           = m_result.last;
    assign m_error_code     = m_result.error_code;

endmodule

`default_nettype wire

@@ rtl/core/lpfd_checker.sv @@
// Port-level checks of the frame decoder, bound to the top level.
// Depends on lpfd_pkg and length_prefixed_frame_decoder_core_macros.svh.
`default_nettype none
`include "length_prefixed_frame_decoder_core_macros.svh"

module lpfd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        cfg_index,
    input wire logic [31:0] cfg_data,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_command,
    input wire logic [7:0]  s_data_byte,
    input wire logic        s_chunk_end,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_kind,
    input wire logic [7:0]  m_channel,
    input wire logic [7:0]  m_frame_flags,
    input wire logic [63:0] m_timestamp,
    input wire logic [31:0] m_payload_length,
    input wire logic [7:0]  m_payload_byte,
    input wire logic        m_last,
    input wire logic [1:0]  m_error_code
);

    // Error reports carry only kind and code.
    `LPFD_ASSERT_NOW(a_error_clean, aclk, aresetn,
        m_valid && m_kind == lpfd_pkg::KIND_ERROR,
        m_channel == 8'd0 && m_frame_flags == 8'd0 && m_timestamp == 64'd0 &&
        m_payload_length == 32'd0 && m_payload_byte == 8'd0 && !m_last &&
        m_error_code != lpfd_pkg::ERR_NONE)

    // Header and payload records never carry an error code.
    `LPFD_ASSERT_NOW(a_frame_no_error, aclk, aresetn,
        m_valid && (m_kind == lpfd_pkg::KIND_HEADER || m_kind == lpfd_pkg::KIND_PAYLOAD),
        m_error_code == lpfd_pkg::ERR_NONE)

    // A header record of a non-empty frame is never marked last.
    `LPFD_ASSERT_NOW(a_header_last, aclk, aresetn,
        m_valid && m_kind == lpfd_pkg::KIND_HEADER,
        m_last == (m_payload_length == 32'd0) && m_payload_byte == 8'd0)

    // A stalled result holds.
    `LPFD_ASSERT_NEXT(a_result_hold, aclk, aresetn,
        m_valid && !m_ready,
        m_valid && $stable(m_kind) && $stable(m_payload_byte) && $stable(m_last))

endmodule

bind length_prefixed_frame_decoder_core lpfd_checker u_lpfd_checker (.*);

`default_nettype wire
